// File: rtl/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared types and constants of the trial division factorizer.
// ----------------------------------------------------------------------------
package tdf_pkg;

  localparam int WIDTH    = 32;
  localparam int FACTOR_W = 32;
  localparam int CNT_W    = $clog2(WIDTH + 1);

  localparam logic [WIDTH-1:0] FIRST_CAND  = WIDTH'(2);
  localparam logic [WIDTH-1:0] SECOND_CAND = WIDTH'(3);
  localparam logic [WIDTH-1:0] CAND_STEP   = WIDTH'(2);
  localparam logic [WIDTH-1:0] ONE         = WIDTH'(1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } tdf_state_t;

  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;
  } tdf_div_req_t;

  typedef struct packed {
    logic             done;
    logic [WIDTH-1:0] quot;
    logic [WIDTH-1:0] remd;
  } tdf_div_rsp_t;

  typedef struct packed {
    logic                valid;
    logic [FACTOR_W-1:0] factor;
    logic                last;
    logic                empty_res;
  } tdf_res_t;

endpackage

// File: rtl/trial_division_factorizer.sv
// ----------------------------------------------------------------------------
// trial_division_factorizer
// Prime factorization of one unsigned integer by trial division.
// ----------------------------------------------------------------------------
// Takes one request at a time and returns its prime factors in non-decreasing
// order, one result each, the final one marked last; 0 and 1 give a single
// result with empty_res set. Every trial of a candidate is one pass of a
// shared bit-serial divider, and the same quotient also serves the square
// root bound, so the cost of a request grows with its number of trials: a
// prime near 2^32 takes some 32768 trials. The input stalls until the last
// result has left the sequencer; a registered output stage holds one result.
module trial_division_factorizer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tdf_pkg::WIDTH-1:0]    in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tdf_pkg::FACTOR_W-1:0] out_factor,
  output logic                         out_last,
  output logic                         out_empty_res
);
  import tdf_pkg::*;

  tdf_div_req_t        div_req;
  tdf_div_rsp_t        div_rsp;
  tdf_res_t            res;
  logic                idle;
  logic                take;
  logic                out_valid_r, out_valid_nxt;
  logic [FACTOR_W-1:0] out_factor_r;
  logic                out_last_r;
  logic                out_empty_res_r;

  assign take     = !out_valid_r || !out_stall;
  assign in_stall = !idle;

  tdf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid && idle),
    .value    (in_value),
    .idle     (idle),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .res      (res),
    .res_take (take)
  );

  tdf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res.valid && take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res.valid && take) begin
      out_factor_r    <= res.factor;
      out_last_r      <= res.last;
      out_empty_res_r <= res.empty_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_factor    = out_factor_r;
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_res_r;

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after request");

  a_empty_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_last && out_factor == '0)
    else $error("empty result not final or nonzero");

  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_res |-> out_factor >= FACTOR_W'(2))
    else $error("factor below two");

  a_no_div_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !div_req.start && !div_rsp.done)
    else $error("divider active while result pending");

endmodule

// File: rtl/tdf_div.sv
// ----------------------------------------------------------------------------
// tdf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdf_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tdf_pkg::tdf_div_req_t req,
  output tdf_pkg::tdf_div_rsp_t rsp
);
  import tdf_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] q_r, q_nxt;
  logic [WIDTH-1:0] d_r, d_nxt;
  logic [WIDTH:0]   diff;

  assign diff = {a_r, q_r[WIDTH-1]} - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(WIDTH);
      a_nxt    = '0;
      q_nxt    = req.dividend;
      d_nxt    = req.divisor;
    end else if (busy_r) begin
      if (diff[WIDTH]) begin
        a_nxt = {a_r[WIDTH-2:0], q_r[WIDTH-1]};
        q_nxt = {q_r[WIDTH-2:0], 1'b0};
      end else begin
        a_nxt = diff[WIDTH-1:0];
        q_nxt = {q_r[WIDTH-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r <= a_nxt;
    q_r <= q_nxt;
    d_r <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.remd = a_r;

endmodule

// File: rtl/tdf_seq.sv
// ----------------------------------------------------------------------------
// tdf_seq
// Sequencer: walks the candidate divisors and drives the shared divider.
// ----------------------------------------------------------------------------
module tdf_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [tdf_pkg::WIDTH-1:0] value,
  output logic                   idle,
  output tdf_pkg::tdf_div_req_t  div_req,
  input  tdf_pkg::tdf_div_rsp_t  div_rsp,
  output tdf_pkg::tdf_res_t      res,
  input  logic                   res_take
);
  import tdf_pkg::*;

  tdf_state_t          state_r, state_nxt;
  logic [WIDTH-1:0]    rem_r, rem_nxt;
  logic [WIDTH-1:0]    cand_r, cand_nxt;
  logic                fin_r, fin_nxt;
  logic                start_r, start_nxt;
  logic [FACTOR_W-1:0] pf_r, pf_nxt;
  logic                pl_r, pl_nxt;
  logic                pe_r, pe_nxt;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    cand_nxt  = cand_r;
    fin_nxt   = fin_r;
    start_nxt = 1'b0;
    pf_nxt    = pf_r;
    pl_nxt    = pl_r;
    pe_nxt    = pe_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (value <= ONE) begin
            pf_nxt    = '0;
            pl_nxt    = 1'b1;
            pe_nxt    = 1'b1;
            fin_nxt   = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            rem_nxt   = value;
            cand_nxt  = FIRST_CAND;
            start_nxt = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          pe_nxt = 1'b0;
          if (cand_r > div_rsp.quot) begin
            // remainder has no factor up to its square root
            pf_nxt    = FACTOR_W'(rem_r);
            pl_nxt    = 1'b1;
            fin_nxt   = 1'b1;
            state_nxt = S_EMIT;
          end else if (div_rsp.remd == '0) begin
            pf_nxt    = FACTOR_W'(cand_r);
            pl_nxt    = (div_rsp.quot == ONE);
            fin_nxt   = (div_rsp.quot == ONE);
            rem_nxt   = div_rsp.quot;
            state_nxt = S_EMIT;
          end else begin
            cand_nxt  = (cand_r == FIRST_CAND) ? SECOND_CAND : cand_r + CAND_STEP;
            start_nxt = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (res_take) begin
          if (fin_r) begin
            state_nxt = S_IDLE;
          end else begin
            start_nxt = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      fin_r   <= fin_nxt;
    end
    rem_r  <= rem_nxt;
    cand_r <= cand_nxt;
    pf_r   <= pf_nxt;
    pl_r   <= pl_nxt;
    pe_r   <= pe_nxt;
  end

  assign idle             = (state_r == S_IDLE);
  assign div_req.start    = start_r;
  assign div_req.dividend = rem_r;
  assign div_req.divisor  = cand_r;
  assign res.valid        = (state_r == S_EMIT);
  assign res.factor       = pf_r;
  assign res.last         = pl_r;
  assign res.empty_res    = pe_r;

endmodule
